// ===== rtl/history_indexed_q_learning_update_unit_assert.svh =====
// Assertion macros used by the checker file of the Q-learning update unit.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef HISTORY_INDEXED_Q_LEARNING_UPDATE_UNIT_ASSERT_SVH
`define HISTORY_INDEXED_Q_LEARNING_UPDATE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HIQLU_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HIQLU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/hiqlu_pkg.sv =====
// Shared types and constants of the history-indexed Q-learning update unit.
// Used by the multiplier, the top level and the checker; depends on nothing.
package hiqlu_pkg;

    // Value widths: Q16.16 entries, 16-bit coefficients, wide intermediates.
    localparam int Q_W    = 32;
    localparam int COEF_W = 16;
    localparam int DIFF_W = 35;
    localparam int PROD_W = COEF_W + 1 + DIFF_W;
    localparam int RND_W  = PROD_W + 1 - 16;
    localparam int SUM_W  = 38;
    localparam int ACT_W  = 4;
    localparam int OBS_W  = 3;
    localparam int MASK_W = 12;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic CFG_IDX_ALPHA = 1'b0;
    localparam logic CFG_IDX_GAMMA = 1'b1;
    localparam logic [COEF_W-1:0] ALPHA_RST = 16'd55706;
    localparam logic [COEF_W-1:0] GAMMA_RST = 16'd62259;

    // Saturation limits of a Q16.16 entry.
    localparam logic [Q_W-1:0] Q_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0] Q_NEG_MAX = 32'h8000_0000;

    typedef enum logic [1:0] {
        OP_WRITE    = 2'd0,
        OP_SELECT   = 2'd1,
        OP_UPDATE   = 2'd2,
        OP_TERMINAL = 2'd3
    } t_opcode;

endpackage

// ===== rtl/hiqlu_ram.sv =====
// Generic single-port RAM with a registered read port.
// Depends on nothing; contents are undefined until written.
module hiqlu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 5184
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One access per cycle: a write, or a read whose data shows up next cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/hiqlu_mul.sv =====
// Shared multiplier: unsigned 16-bit coefficient times a signed wide operand.
// Depends on hiqlu_pkg for the widths; the product is registered.
module hiqlu_mul
    import hiqlu_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [COEF_W-1:0]        i_coef,
    input  logic signed [DIFF_W-1:0] i_operand,
    output logic signed [PROD_W-1:0] o_product
);

    logic signed [PROD_W-1:0] r_product;

    // The coefficient gets a zero sign bit so the signed multiply stays exact.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_product <= $signed({1'b0, i_coef}) * i_operand;
        end
    end

    assign o_product = r_product;

endmodule

// ===== rtl/history_indexed_q_learning_update_unit.sv =====
// History-indexed Q-learning update unit.
// Input channel: i_in_valid with o_in_stall; an item is taken when valid is high and
// stall is low. Output channel: o_out_valid with i_out_stall, one result per item.
// Configuration: APB-style port; learning rate at 0x0, discount at 0x4, both 16 bits.
// One item is worked on at a time; o_in_stall stays high until its result is
// placed in the output register. Every item passes the address and base states.
// A write then writes the entry; a select scans the current row once per action
// on the single-port table RAM; an update scans the next row and scales its best
// value by the discount; update and terminal then read the entry, form the
// difference, scale it by the learning rate and write the saturated new value.
// One shared multiplier forms both the discount and the learning-rate products.
// The output register holds a result while the receiver stalls; the next item is
// still accepted, and its result waits in the finishing state until the register
// frees up.
// Reset clears control state and loads the default rates; the table is not cleared,
// and its entries are undefined until written.
// Depends on hiqlu_pkg, hiqlu_ram and hiqlu_mul.
module history_indexed_q_learning_update_unit
    import hiqlu_pkg::*;
#(
    parameter int NUM_OBSERVATIONS = 6,
    parameter int NUM_ACTIONS      = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Input channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_opcode,
    input  logic [OBS_W-1:0]    i_older_obs,
    input  logic [ACT_W-1:0]    i_history_action,
    input  logic [OBS_W-1:0]    i_latest_obs,
    input  logic [ACT_W-1:0]    i_taken_action,
    input  logic signed [Q_W-1:0] i_step_reward,
    input  logic [OBS_W-1:0]    i_next_obs,
    input  logic [MASK_W-1:0]   i_legal_mask,
    input  logic signed [Q_W-1:0] i_load_value,
    // Output channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [ACT_W-1:0]    o_best_action,
    output logic signed [Q_W-1:0] o_q_result,
    output logic                o_saturated,
    // Configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    localparam int ROW_CNT = NUM_OBSERVATIONS * NUM_ACTIONS * NUM_OBSERVATIONS;
    localparam int ROW_W   = $clog2(ROW_CNT);
    localparam int DEPTH   = ROW_CNT * NUM_ACTIONS;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam logic [OBS_W-1:0] OBS_LAST = OBS_W'(NUM_OBSERVATIONS - 1);
    localparam logic [ACT_W-1:0] ACT_LAST = ACT_W'(NUM_ACTIONS - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADDR,
        S_BASE,
        S_WRITE,
        S_SCAN,
        S_SDRAIN,
        S_SRES,
        S_READ,
        S_GMUL,
        S_DIFF,
        S_AMUL,
        S_NEW,
        S_OUT
    } t_state;

    t_state                    r_state;
    logic [COEF_W-1:0]         r_alpha;
    logic [COEF_W-1:0]         r_gamma;

    // Captured item
    t_opcode                   r_op;
    logic [OBS_W-1:0]          r_old;
    logic [ACT_W-1:0]          r_hact;
    logic [OBS_W-1:0]          r_lat;
    logic [ACT_W-1:0]          r_tact;
    logic [OBS_W-1:0]          r_nxt;
    logic [2**ACT_W-1:0]       r_mask;
    logic signed [Q_W-1:0]     r_reward;
    logic signed [Q_W-1:0]     r_load;

    // Addressing and scan state
    logic [ROW_W-1:0]          r_cur_row;
    logic [ROW_W-1:0]          r_nxt_row;
    logic [ADDR_W-1:0]         r_entry;
    logic [ADDR_W-1:0]         r_scan_base;
    logic [ACT_W-1:0]          r_cnt;
    logic                      r_rd_vld;
    logic [ACT_W-1:0]          r_rd_idx;
    logic signed [Q_W-1:0]     r_bv;
    logic [ACT_W-1:0]          r_best;

    // Arithmetic state
    logic signed [Q_W-1:0]     r_cur;
    logic signed [DIFF_W-1:0]  r_diff;

    // Pending and delivered result
    logic [ACT_W-1:0]          r_p_best;
    logic [Q_W-1:0]            r_p_res;
    logic                      r_p_sat;
    logic                      r_out_vld;
    logic [ACT_W-1:0]          r_out_best;
    logic [Q_W-1:0]            r_out_res;
    logic                      r_out_sat;

    logic                      in_acc;
    logic                      out_free;
    logic [OBS_W-1:0]          old_c;
    logic [OBS_W-1:0]          lat_c;
    logic [OBS_W-1:0]          nxt_c;
    logic [ACT_W-1:0]          hact_c;
    logic [ACT_W-1:0]          tact_c;

    logic                      ram_we;
    logic [ADDR_W-1:0]         ram_addr;
    logic [Q_W-1:0]            ram_wdata;
    logic [Q_W-1:0]            ram_rdata;
    logic signed [Q_W-1:0]     ram_q;

    logic                      mul_en;
    logic [COEF_W-1:0]         mul_coef;
    logic signed [DIFF_W-1:0]  mul_operand;
    logic signed [PROD_W-1:0]  mul_product;

    logic                      take;
    logic signed [PROD_W:0]    rnd_sum;
    logic signed [RND_W-1:0]   rnd_val;
    logic signed [RND_W-1:0]   t_val;
    logic signed [SUM_W-1:0]   diff_w;
    logic signed [SUM_W-1:0]   nv;
    logic                      sat_hi;
    logic                      sat_lo;
    logic [Q_W-1:0]            sat_val;

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_vld || !i_out_stall;

    // Out-of-range observations and actions clamp to the largest valid value.
    assign old_c  = (32'(i_older_obs) >= NUM_OBSERVATIONS) ? OBS_LAST : i_older_obs;
    assign lat_c  = (32'(i_latest_obs) >= NUM_OBSERVATIONS) ? OBS_LAST : i_latest_obs;
    assign nxt_c  = (32'(i_next_obs) >= NUM_OBSERVATIONS) ? OBS_LAST : i_next_obs;
    assign hact_c = (32'(i_history_action) >= NUM_ACTIONS) ? ACT_LAST : i_history_action;
    assign tact_c = (32'(i_taken_action) >= NUM_ACTIONS) ? ACT_LAST : i_taken_action;

    // Configuration registers; the register is picked by the word address bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_RST;
            r_gamma <= GAMMA_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                CFG_IDX_ALPHA: r_alpha <= pwdata[COEF_W-1:0];
                CFG_IDX_GAMMA: r_gamma <= pwdata[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    assign prdata = (paddr[2] == CFG_IDX_GAMMA) ? PDATA_W'(r_gamma) : PDATA_W'(r_alpha);
    assign pready = 1'b1;

    // Table memory and the shared multiplier.
    hiqlu_ram #(
        .WIDTH(Q_W),
        .DEPTH(DEPTH)
    ) u_qtab (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    hiqlu_mul u_mul (
        .i_clk    (i_clk),
        .i_en     (mul_en),
        .i_coef   (mul_coef),
        .i_operand(mul_operand),
        .o_product(mul_product)
    );

    assign ram_q = $signed(ram_rdata);

    // Memory port and multiplier operand selection by state.
    always_comb begin
        ram_we      = (r_state == S_WRITE) || (r_state == S_NEW);
        ram_wdata   = (r_state == S_WRITE) ? r_load : sat_val;
        ram_addr    = r_entry;
        if (r_state == S_SCAN) begin
            ram_addr = ADDR_W'(r_scan_base + ADDR_W'(r_cnt));
        end
        mul_en      = (r_state == S_GMUL) || (r_state == S_AMUL);
        mul_coef    = (r_state == S_GMUL) ? r_gamma : r_alpha;
        mul_operand = (r_state == S_GMUL) ? DIFF_W'(r_bv) : r_diff;
    end

    // Greedy scan step: the first entry is the start candidate only if legal,
    // otherwise action one starts unconditionally; ties keep the lower action.
    always_comb begin
        if (r_rd_idx == '0) begin
            take = r_mask[0];
        end else if (r_rd_idx == ACT_W'(1)) begin
            take = !r_mask[0] || (r_mask[1] && (ram_q > r_bv));
        end else begin
            take = r_mask[r_rd_idx] && (ram_q > r_bv);
        end
    end

    // Round half up after the 16-bit fraction shift, then form the update terms.
    always_comb begin
        rnd_sum = $signed({mul_product[PROD_W-1], mul_product}) + (PROD_W+1)'(32768);
        rnd_val = rnd_sum[PROD_W:16];
        t_val   = (r_op == OP_TERMINAL) ? '0 : rnd_val;
        diff_w  = SUM_W'(r_reward) + SUM_W'(t_val) - SUM_W'(ram_q);
        nv      = SUM_W'(r_cur) + SUM_W'(rnd_val);
        sat_hi  = !nv[SUM_W-1] && (nv[SUM_W-2:Q_W-1] != '0);
        sat_lo  = nv[SUM_W-1] && (nv[SUM_W-2:Q_W-1] != '1);
        if (sat_hi) begin
            sat_val = Q_POS_MAX;
        end else if (sat_lo) begin
            sat_val = Q_NEG_MAX;
        end else begin
            sat_val = nv[Q_W-1:0];
        end
    end

    // Sequencer, datapath registers and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_rd_vld  <= 1'b0;
        end else begin
            // The output register empties when its item is taken, unless the
            // finishing state refills it in the same cycle.
            if (r_out_vld && !i_out_stall && (r_state != S_OUT)) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_op     <= t_opcode'(i_opcode);
                        r_old    <= old_c;
                        r_hact   <= hact_c;
                        r_lat    <= lat_c;
                        r_tact   <= tact_c;
                        r_nxt    <= nxt_c;
                        r_mask   <= (2**ACT_W)'(i_legal_mask);
                        r_reward <= i_step_reward;
                        r_load   <= i_load_value;
                        r_state  <= S_ADDR;
                    end
                end
                S_ADDR: begin
                    r_cur_row <= ROW_W'((32'(r_old) * NUM_ACTIONS + 32'(r_hact))
                                        * NUM_OBSERVATIONS + 32'(r_lat));
                    r_nxt_row <= ROW_W'((32'(r_lat) * NUM_ACTIONS + 32'(r_tact))
                                        * NUM_OBSERVATIONS + 32'(r_nxt));
                    r_state   <= S_BASE;
                end
                S_BASE: begin
                    r_entry <= ADDR_W'(32'(r_cur_row) * NUM_ACTIONS + 32'(r_tact));
                    if (r_op == OP_SELECT) begin
                        r_scan_base <= ADDR_W'(32'(r_cur_row) * NUM_ACTIONS);
                    end else begin
                        r_scan_base <= ADDR_W'(32'(r_nxt_row) * NUM_ACTIONS);
                    end
                    r_cnt    <= '0;
                    r_rd_vld <= 1'b0;
                    case (r_op)
                        OP_WRITE:    r_state <= S_WRITE;
                        OP_TERMINAL: r_state <= S_READ;
                        default:     r_state <= S_SCAN;
                    endcase
                end
                S_WRITE: begin
                    r_p_best <= '0;
                    r_p_res  <= r_load;
                    r_p_sat  <= 1'b0;
                    r_state  <= S_OUT;
                end
                S_SCAN: begin
                    if (r_rd_vld && take) begin
                        r_bv   <= ram_q;
                        r_best <= r_rd_idx;
                    end
                    r_rd_vld <= 1'b1;
                    r_rd_idx <= r_cnt;
                    r_cnt    <= r_cnt + ACT_W'(1);
                    if (r_cnt == ACT_LAST) begin
                        r_state <= S_SDRAIN;
                    end
                end
                S_SDRAIN: begin
                    if (take) begin
                        r_bv   <= ram_q;
                        r_best <= r_rd_idx;
                    end
                    r_rd_vld <= 1'b0;
                    r_state  <= (r_op == OP_SELECT) ? S_SRES : S_GMUL;
                end
                S_SRES: begin
                    r_p_best <= r_best;
                    r_p_res  <= r_bv;
                    r_p_sat  <= 1'b0;
                    r_state  <= S_OUT;
                end
                S_READ: begin
                    r_state <= S_DIFF;
                end
                S_GMUL: begin
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    r_cur   <= ram_q;
                    r_diff  <= DIFF_W'(diff_w);
                    r_state <= S_AMUL;
                end
                S_AMUL: begin
                    r_state <= S_NEW;
                end
                S_NEW: begin
                    r_p_best <= (r_op == OP_UPDATE) ? r_best : '0;
                    r_p_res  <= sat_val;
                    r_p_sat  <= sat_hi || sat_lo;
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_vld  <= 1'b1;
                        r_out_best <= r_p_best;
                        r_out_res  <= r_p_res;
                        r_out_sat  <= r_p_sat;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_vld;
    assign o_best_action = r_out_best;
    assign o_q_result    = $signed(r_out_res);
    assign o_saturated   = r_out_sat;

endmodule

// ===== rtl/hiqlu_checker.sv =====
// Port-level assertions for the Q-learning update unit, bound to the top level.
// Depends on hiqlu_pkg and the assertion macro header.
`include "history_indexed_q_learning_update_unit_assert.svh"

module hiqlu_checker
    import hiqlu_pkg::*;
#(
    parameter int NUM_ACTIONS = 12
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [ACT_W-1:0]     o_best_action,
    input logic signed [Q_W-1:0] o_q_result,
    input logic                 o_saturated
);

    localparam logic [ACT_W-1:0] ACT_LAST = ACT_W'(NUM_ACTIONS - 1);

    // A stalled result holds its payload.
    `HIQLU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_q_result) && $stable(o_best_action) && $stable(o_saturated), "stalled result changed")

    // Each accepted item keeps the block busy in the following cycle.
    `HIQLU_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input taken again right after an item")

    // A new result appears only as the block finishes its item.
    `HIQLU_ASSERT_NOW(a_result_at_finish, i_clk, i_rst_n, $rose(o_out_valid), !o_in_stall && $past(o_in_stall), "result appeared outside item completion")

    // Saturation reports a clipped value, and the action is always a real one.
    `HIQLU_ASSERT_NOW(a_result_range, i_clk, i_rst_n, o_out_valid, (o_best_action <= ACT_LAST) && (!o_saturated || o_q_result == $signed(Q_POS_MAX) || o_q_result == $signed(Q_NEG_MAX)), "result fields out of range")

endmodule

bind history_indexed_q_learning_update_unit hiqlu_checker #(
    .NUM_ACTIONS(NUM_ACTIONS)
) u_hiqlu_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_best_action(o_best_action),
    .o_q_result   (o_q_result),
    .o_saturated  (o_saturated)
);
